@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge out of reset
`define FL_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: lbl");

// a implies c in the same cycle
`define FL_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: lbl");

// a implies c in the next cycle
`define FL_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: lbl");

`endif

@@ rtl/core/rfla_pkg.sv @@
// ----------------------------------------------------------------------------
// rfla_pkg
// Types and codes shared by the ring free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfla_pkg;

   localparam int START_W = 22;
   localparam int LEN_W   = 23;
   localparam int SIZE_W  = 24;
   localparam int ALIGN_W = 25;

   typedef logic [1:0] action_type;
   typedef logic [2:0] status_type;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } slot_type;

   localparam action_type ACT_ALLOC = 2'd0;
   localparam action_type ACT_FREE  = 2'd1;
   localparam action_type ACT_SORT  = 2'd2;

   localparam status_type ST_ALLOCATED  = 3'd0;
   localparam status_type ST_NO_FIT     = 3'd1;
   localparam status_type ST_MERGED     = 3'd2;
   localparam status_type ST_NEW_SLOT   = 3'd3;
   localparam status_type ST_OUTSIDE    = 3'd4;
   localparam status_type ST_IGNORED    = 3'd5;
   localparam status_type ST_FULL       = 3'd6;
   localparam status_type ST_REARRANGED = 3'd7;

endpackage

@@ rtl/core/rfla_ram.sv @@
// ----------------------------------------------------------------------------
// rfla_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfla_ram #(
   parameter int WIDTH = 45,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ring_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// ring_free_list_allocator_top
// First-fit free-list allocator over a ring of free slots, with coalescing.
// ----------------------------------------------------------------------------
// One request is worked at a time by a sequencer around two slot RAMs, the ring
// and a sort buffer, each with one read port. Allocate and free scan the ring
// slots in turn from the head. Rearrange makes n selection passes over the n
// slots, merging adjacent ones, then copies the result back to the ring.
// After reset or a write to the register the S_INIT state rebuilds the first
// slot before requests are taken. A finished result waits in an output
// register while the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ring_free_list_allocator_top
   import rfla_pkg::*;
#(
   parameter int SLOT_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [23:0] req_request_size,
   input  logic [23:0] req_free_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [21:0] rsp_alloc_offset,
   output logic [6:0]  rsp_slots_in_use
);

   localparam int IW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int PW = $clog2(SLOT_COUNT) + 17;

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_SCAN_A  = 4'd2;
   localparam logic [3:0] S_SCAN_B  = 4'd3;
   localparam logic [3:0] S_APPEND  = 4'd4;
   localparam logic [3:0] S_SORT_A  = 4'd5;
   localparam logic [3:0] S_SORT_B  = 4'd6;
   localparam logic [3:0] S_SORT_E  = 4'd7;
   localparam logic [3:0] S_FLUSH   = 4'd8;
   localparam logic [3:0] S_COPY_A  = 4'd9;
   localparam logic [3:0] S_COPY_B  = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] v);
      ring_inc = (v == IW'(SLOT_COUNT - 1)) ? '0 : v + 1'b1;
   endfunction

   logic [3:0]         state_ff, state_in;
   logic [4:0]         log2_ff, log2_in;
   logic [IW-1:0]      head_ff, head_in, tail_ff, tail_in, idx_ff, idx_in;
   logic [CW-1:0]      total_ff, total_in, k_ff, k_in;
   logic [CW-1:0]      pass_ff, pass_in, last_ff, last_in;
   logic               live_ff, live_in;
   action_type         act_ff, act_in;
   logic [ALIGN_W-1:0] aligned_ff, aligned_in;
   logic [SIZE_W-1:0]  off_ff, off_in;
   status_type         status_ff, status_in;
   logic [START_W-1:0] aoff_ff, aoff_in;
   slot_type           hd_ff, hd_in, cur_ff, cur_in, best_ff, best_in;
   logic               best_v_ff, best_v_in;
   logic [CW-1:0]      best_k_ff, best_k_in, prev_k_ff, prev_k_in;
   logic [START_W-1:0] prev_start_ff, prev_start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [21:0]        rsp_aoff_ff, rsp_aoff_in;
   logic [6:0]         rsp_used_ff, rsp_used_in;

   logic               a_we, b_we;
   logic [IW-1:0]      a_waddr, b_waddr;
   slot_type           a_wdata, b_wdata, a_rdata, b_rdata;

   logic [4:0]         eff;
   logic [ALIGN_W-1:0] blk_mask;
   logic [PW-1:0]      pool_bytes;
   logic               req_accept;
   logic               k_last, cand, take;

   rfla_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOT_COUNT)) u_ring_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (idx_ff),
      .rd_data (a_rdata)
   );

   rfla_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOT_COUNT)) u_sort_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (k_ff[IW-1:0]),
      .rd_data (b_rdata)
   );

   assign eff        = (log2_ff > 5'd16) ? 5'd16 : log2_ff;
   assign blk_mask   = (ALIGN_W'(1) << eff) - 1'b1;
   assign pool_bytes = PW'(SLOT_COUNT) << eff;
   assign req_stall  = (state_ff != S_IDLE) || csr_wr_en;
   assign req_accept = req_valid && !req_stall;
   assign k_last     = ((k_ff + 1'b1) == total_ff);
   assign cand       = (pass_ff == '0) || (a_rdata.start > prev_start_ff) ||
                       ((a_rdata.start == prev_start_ff) && (k_ff > prev_k_ff));
   assign take       = cand && (!best_v_ff || (a_rdata.start < best_ff.start));

   always_comb begin
      state_in      = state_ff;
      log2_in       = log2_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      idx_in        = idx_ff;
      total_in      = total_ff;
      k_in          = k_ff;
      pass_in       = pass_ff;
      last_in       = last_ff;
      live_in       = live_ff;
      act_in        = act_ff;
      aligned_in    = aligned_ff;
      off_in        = off_ff;
      status_in     = status_ff;
      aoff_in       = aoff_ff;
      hd_in         = hd_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      best_v_in     = best_v_ff;
      best_k_in     = best_k_ff;
      prev_k_in     = prev_k_ff;
      prev_start_in = prev_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_aoff_in   = rsp_aoff_ff;
      rsp_used_in   = rsp_used_ff;
      a_we          = 1'b0;
      a_waddr       = idx_ff;
      a_wdata       = a_rdata;
      b_we          = 1'b0;
      b_waddr       = last_ff[IW-1:0];
      b_wdata       = cur_ff;

      unique case (state_ff)
         S_INIT: begin
            a_we          = 1'b1;
            a_waddr       = '0;
            a_wdata.start = '0;
            a_wdata.len   = LEN_W'(pool_bytes);
            head_in       = '0;
            tail_in       = ring_inc('0);
            total_in      = CW'(1);
            live_in       = 1'b0;
            state_in      = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               act_in     = req_action;
               off_in     = req_free_offset;
               aligned_in = ({1'b0, req_request_size} + blk_mask) & ~blk_mask;
               aoff_in    = '0;
               k_in       = '0;
               idx_in     = head_ff;
               state_in   = S_DONE;
               unique case (req_action)
                  ACT_ALLOC: begin
                     live_in = 1'b1;
                     if (total_ff == '0) begin
                        status_in = ST_NO_FIT;
                     end else begin
                        state_in = S_SCAN_A;
                     end
                  end
                  ACT_FREE: begin
                     priority if (!live_ff) begin
                        status_in = ST_IGNORED;
                     end else if (32'(req_free_offset) >= 32'(pool_bytes)) begin
                        status_in = ST_OUTSIDE;
                     end else if (total_ff == '0) begin
                        state_in = S_APPEND;
                     end else begin
                        state_in = S_SCAN_A;
                     end
                  end
                  ACT_SORT: begin
                     pass_in   = '0;
                     last_in   = '0;
                     best_v_in = 1'b0;
                     status_in = ST_REARRANGED;
                     if (total_ff != '0) begin
                        state_in = S_SORT_A;
                     end
                  end
                  default: begin
                     status_in = ST_IGNORED;
                  end
               endcase
            end
         end
         S_SCAN_A: begin
            state_in = S_SCAN_B;
         end
         S_SCAN_B: begin
            if (k_ff == '0) begin
               hd_in = a_rdata;
            end
            k_in     = k_ff + 1'b1;
            idx_in   = ring_inc(idx_ff);
            state_in = S_SCAN_A;
            if (act_ff == ACT_ALLOC) begin
               if (ALIGN_W'(a_rdata.len) >= aligned_ff) begin
                  aoff_in   = a_rdata.start;
                  status_in = ST_ALLOCATED;
                  state_in  = S_DONE;
                  if (ALIGN_W'(a_rdata.len) == aligned_ff) begin
                     a_we     = (k_ff != '0);
                     a_wdata  = hd_ff;
                     head_in  = ring_inc(head_ff);
                     total_in = total_ff - 1'b1;
                  end else begin
                     a_we          = 1'b1;
                     a_wdata.start = a_rdata.start + aligned_ff[START_W-1:0];
                     a_wdata.len   = a_rdata.len - aligned_ff[LEN_W-1:0];
                  end
               end else if (k_last) begin
                  status_in = ST_NO_FIT;
                  state_in  = S_DONE;
               end
            end else begin
               if ((26'(off_ff) + 26'(aligned_ff)) == 26'(a_rdata.start)) begin
                  a_we          = 1'b1;
                  a_wdata.start = off_ff[START_W-1:0];
                  a_wdata.len   = a_rdata.len + aligned_ff[LEN_W-1:0];
                  status_in     = ST_MERGED;
                  state_in      = S_DONE;
               end else if (k_last) begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            state_in = S_DONE;
            if (total_ff >= CW'(SLOT_COUNT)) begin
               status_in = ST_FULL;
            end else begin
               a_we          = 1'b1;
               a_waddr       = tail_ff;
               a_wdata.start = off_ff[START_W-1:0];
               a_wdata.len   = aligned_ff[LEN_W-1:0];
               tail_in       = ring_inc(tail_ff);
               total_in      = total_ff + 1'b1;
               status_in     = ST_NEW_SLOT;
            end
         end
         S_SORT_A: begin
            state_in = S_SORT_B;
         end
         S_SORT_B: begin
            if (take) begin
               best_v_in = 1'b1;
               best_in   = a_rdata;
               best_k_in = k_ff;
            end
            if (k_last) begin
               state_in = S_SORT_E;
            end else begin
               k_in     = k_ff + 1'b1;
               idx_in   = ring_inc(idx_ff);
               state_in = S_SORT_A;
            end
         end
         S_SORT_E: begin
            priority if (pass_ff == '0) begin
               cur_in = best_ff;
            end else if ((24'(cur_ff.start) + 24'(cur_ff.len)) == 24'(best_ff.start)) begin
               cur_in.len = cur_ff.len + best_ff.len;
            end else begin
               b_we    = 1'b1;
               last_in = last_ff + 1'b1;
               cur_in  = best_ff;
            end
            prev_start_in = best_ff.start;
            prev_k_in     = best_k_ff;
            pass_in       = pass_ff + 1'b1;
            k_in          = '0;
            idx_in        = head_ff;
            best_v_in     = 1'b0;
            state_in      = ((pass_ff + 1'b1) == total_ff) ? S_FLUSH : S_SORT_A;
         end
         S_FLUSH: begin
            b_we     = 1'b1;
            k_in     = '0;
            state_in = S_COPY_A;
         end
         S_COPY_A: begin
            state_in = S_COPY_B;
         end
         S_COPY_B: begin
            a_we    = 1'b1;
            a_waddr = k_ff[IW-1:0];
            a_wdata = b_rdata;
            if (k_ff == last_ff) begin
               head_in  = '0;
               total_in = last_ff + 1'b1;
               tail_in  = (last_ff == CW'(SLOT_COUNT - 1)) ? '0 : IW'(last_ff + 1'b1);
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_COPY_A;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_aoff_in   = aoff_ff;
               rsp_used_in   = 7'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      if (csr_wr_en) begin
         log2_in  = csr_wr_data;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         log2_ff      <= 5'd5;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= CW'(1);
         live_ff      <= 1'b0;
         k_ff         <= '0;
         pass_ff      <= '0;
         last_ff      <= '0;
         best_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         log2_ff      <= log2_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         live_ff      <= live_in;
         k_ff         <= k_in;
         pass_ff      <= pass_in;
         last_ff      <= last_in;
         best_v_ff    <= best_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      act_ff        <= act_in;
      aligned_ff    <= aligned_in;
      off_ff        <= off_in;
      status_ff     <= status_in;
      aoff_ff       <= aoff_in;
      hd_ff         <= hd_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      best_k_ff     <= best_k_in;
      prev_k_ff     <= prev_k_in;
      prev_start_ff <= prev_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_aoff_ff   <= rsp_aoff_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_aoff_ff;
   assign rsp_slots_in_use = rsp_used_ff;

   `FL_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= CW'(SLOT_COUNT))
   `FL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall)
   `FL_ASSERT_IMPL(a_offset_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_ALLOCATED), rsp_aoff_ff == '0)

endmodule

@@ sim/ring_free_list_allocator_top_test.sv @@
// ----------------------------------------------------------------------------
// ring_free_list_allocator_top_test
// Drives allocate, free and rearrange requests into the ring free-list
// allocator across several block sizes. Every response is compared against
// a local model of the free ring or a directed table row. The stimulus covers these cases:
//   - a short table of directed corner cases
//   - filling the ring until it is full
//   - random allocations and frees, most frees returning live allocations
// Both handshakes see random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ring_free_list_allocator_top_test;
   import rfla_pkg::*;

   localparam int RING = 64;
   localparam action_type ACT_UNKNOWN = 2'd3;

   typedef struct {
      status_type  st;
      logic [21:0] off;
      logic [6:0]  slots;
   } alloc_result_type;

   typedef struct {
      action_type  act;
      logic [23:0] size;
      logic [23:0] off;
      bit          typed;
      status_type  st;
      logic [21:0] roff;
      logic [6:0]  slots;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [4:0]  csr_wr_data = 5'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = 2'd0;
   logic [23:0] req_request_size = 24'd0;
   logic [23:0] req_free_offset = 24'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [21:0] rsp_alloc_offset;
   logic [6:0]  rsp_slots_in_use;

   ring_free_list_allocator_top #(.SLOT_COUNT(RING)) dut (.*);

   always #5 clock = ~clock;

   // free ring state
   logic [21:0] ring_start [RING];
   logic [22:0] ring_len [RING];
   int unsigned ring_head, ring_tail, ring_total;
   bit          pool_live;
   logic [4:0]  blk_log2;

   alloc_result_type awaited_results[$];
   longint unsigned live_off[$], live_size[$];
   int error_count = 0, transfers = 0, results_seen = 0, full_hits = 0, merges = 0;
   int burst_left = 0;

   function automatic int unsigned eff_log2();
      return (blk_log2 > 16) ? 16 : blk_log2;
   endfunction

   function automatic longint unsigned pool_size();
      return longint'(RING) << eff_log2();
   endfunction

   function automatic longint unsigned round_blk(longint unsigned sz);
      longint unsigned b;
      b = longint'(1) << eff_log2();
      return (sz + b - 1) & ~(b - 1);
   endfunction

   function automatic void ring_init();
      foreach (ring_start[i]) begin
         ring_start[i] = '0;
         ring_len[i] = '0;
      end
      ring_len[0] = 23'(pool_size());
      ring_head = 0;
      ring_tail = 1;
      ring_total = 1;
      pool_live = 0;
   endfunction

   function automatic alloc_result_type allocator_predict(action_type act,
                                                          longint unsigned sz,
                                                          longint unsigned off);
      alloc_result_type r;
      longint unsigned aligned, s_arr[RING], l_arr[RING], s, l;
      int unsigned i, j, last;
      bit done;
      r.st = ST_IGNORED;
      r.off = '0;
      done = 0;
      case (act)
         ACT_ALLOC: begin
            aligned = round_blk(sz);
            pool_live = 1;
            r.st = ST_NO_FIT;
            for (int unsigned k = 0; k < ring_total && !done; k++) begin
               i = (ring_head + k) % RING;
               if (ring_len[i] >= aligned) begin
                  done = 1;
                  r.st = ST_ALLOCATED;
                  r.off = ring_start[i];
                  if (ring_len[i] == aligned) begin
                     if (k != 0) begin
                        ring_start[i] = ring_start[ring_head];
                        ring_len[i] = ring_len[ring_head];
                     end
                     ring_head = (ring_head + 1) % RING;
                     ring_total--;
                  end else begin
                     ring_start[i] = 22'(ring_start[i] + aligned);
                     ring_len[i] = 23'(ring_len[i] - aligned);
                  end
               end
            end
         end
         ACT_FREE: begin
            if (!pool_live) r.st = ST_IGNORED;
            else if (off >= pool_size()) r.st = ST_OUTSIDE;
            else begin
               aligned = round_blk(sz);
               for (int unsigned k = 0; k < ring_total && !done; k++) begin
                  i = (ring_head + k) % RING;
                  if (off + aligned == ring_start[i]) begin
                     ring_start[i] = 22'(off);
                     ring_len[i] = 23'(ring_len[i] + aligned);
                     r.st = ST_MERGED;
                     done = 1;
                  end
               end
               if (!done) begin
                  if (ring_total >= RING) r.st = ST_FULL;
                  else begin
                     ring_start[ring_tail] = 22'(off);
                     ring_len[ring_tail] = 23'(aligned);
                     ring_tail = (ring_tail + 1) % RING;
                     ring_total++;
                     r.st = ST_NEW_SLOT;
                  end
               end
            end
         end
         ACT_SORT: begin
            r.st = ST_REARRANGED;
            if (ring_total != 0) begin
               for (int unsigned k = 0; k < ring_total; k++) begin
                  i = (ring_head + k) % RING;
                  s = ring_start[i];
                  l = ring_len[i];
                  j = k;
                  while (j > 0 && s_arr[j-1] > s) begin
                     s_arr[j] = s_arr[j-1];
                     l_arr[j] = l_arr[j-1];
                     j--;
                  end
                  s_arr[j] = s;
                  l_arr[j] = l;
               end
               ring_start[0] = 22'(s_arr[0]);
               ring_len[0] = 23'(l_arr[0]);
               last = 0;
               for (int unsigned k = 1; k < ring_total; k++) begin
                  if (longint'(ring_start[last]) + ring_len[last] == s_arr[k])
                     ring_len[last] = 23'(ring_len[last] + l_arr[k]);
                  else begin
                     last++;
                     ring_start[last] = 22'(s_arr[k]);
                     ring_len[last] = 23'(l_arr[k]);
                  end
               end
               ring_head = 0;
               ring_total = last + 1;
               ring_tail = ring_total % RING;
            end
         end
         default: r.st = ST_IGNORED;
      endcase
      r.slots = 7'(ring_total);
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, want %0d (%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   // receiver stall pattern: quiet, light, heavy or periodic
   int stall_mode = 0, stall_age = 0;
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_age <= $urandom_range(20, 120);
      end else begin
         stall_age <= stall_age - 1;
      end
      case (stall_mode)
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= ($urandom_range(0, 99) < 75);
         3: rsp_stall <= (stall_age % 4) != 0;
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(negedge clock) begin
      alloc_result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            $display("unexpected transfer on response channel (%0t)", $realtime);
            error_count++;
         end else begin
            w = awaited_results.pop_front();
            if (rsp_status !== w.st) report("status", rsp_status, w.st);
            if (rsp_alloc_offset !== w.off) report("alloc_offset", rsp_alloc_offset, w.off);
            if (rsp_slots_in_use !== w.slots) report("slots_in_use", rsp_slots_in_use, w.slots);
         end
      end
   end

   task automatic send(action_type act, logic [23:0] sz, logic [23:0] off,
                       bit typed = 0, status_type st = ST_ALLOCATED,
                       logic [21:0] roff = '0, logic [6:0] slots = '0);
      alloc_result_type r;
      r = allocator_predict(act, sz, off);
      if (typed) begin
         r.st = st;
         r.off = roff;
         r.slots = slots;
      end
      if (r.st == ST_ALLOCATED && act == ACT_ALLOC) begin
         live_off.insert(live_off.size(), r.off);
         live_size.insert(live_size.size(), sz);
      end
      if (r.st == ST_FULL) full_hits++;
      if (r.st == ST_MERGED) merges++;
      awaited_results.insert(awaited_results.size(), r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_action <= act;
      req_request_size <= sz;
      req_free_offset <= off;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      transfers++;
   endtask

   // hold until every awaited result has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_block_log2(logic [4:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      blk_log2 = v;
      ring_init();
      live_off.delete();
      live_size.delete();
      repeat (2) @(posedge clock);
   endtask

   task automatic random_phase(int n_items);
      int r, idx;
      longint unsigned psz;
      int unsigned lg;
      lg = eff_log2();
      psz = pool_size();
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            send(ACT_ALLOC, 24'($urandom_range(0, 3 << lg)), '0);
         end else if (r < 85) begin
            if (live_off.size() != 0 && $urandom_range(0, 3) != 0) begin
               idx = $urandom_range(0, live_off.size() - 1);
               send(ACT_FREE, 24'(live_size[idx]), 24'(live_off[idx]));
               live_off.delete(idx);
               live_size.delete(idx);
            end else begin
               send(ACT_FREE, 24'($urandom_range(0, 2 << lg)),
                    24'($urandom_range(0, 32'(psz - 1))));
            end
         end else if (r < 90) begin
            send(ACT_SORT, 24'($urandom()), 24'($urandom()));
         end else if (r < 93) begin
            send(ACT_UNKNOWN, 24'($urandom()), 24'($urandom()));
         end else begin
            send(action_type'($urandom_range(0, 1)), 24'($urandom()), 24'($urandom()));
         end
      end
   endtask

   table_row_type directed_rows[] = '{
      '{ACT_FREE,    24'd32,       24'd0,        1, ST_IGNORED,    22'd0,  7'd1},
      '{ACT_UNKNOWN, 24'hFFFFFF,   24'hFFFFFF,   1, ST_IGNORED,    22'd0,  7'd1},
      '{ACT_ALLOC,   24'd0,        24'd0,        1, ST_ALLOCATED,  22'd0,  7'd1},
      '{ACT_ALLOC,   24'd1,        24'd0,        1, ST_ALLOCATED,  22'd0,  7'd1},
      '{ACT_FREE,    24'd32,       24'd2048,     1, ST_OUTSIDE,    22'd0,  7'd1},
      '{ACT_FREE,    24'hFFFFFF,   24'hFFFFFF,   1, ST_OUTSIDE,    22'd0,  7'd1},
      '{ACT_ALLOC,   24'hFFFFFF,   24'd0,        1, ST_NO_FIT,     22'd0,  7'd1},
      '{ACT_SORT,    24'd0,        24'd0,        1, ST_REARRANGED, 22'd0,  7'd1},
      '{ACT_ALLOC,   24'd2016,     24'd0,        1, ST_ALLOCATED,  22'd32, 7'd0},
      '{ACT_ALLOC,   24'd1,        24'd0,        1, ST_NO_FIT,     22'd0,  7'd0},
      '{ACT_SORT,    24'd0,        24'd0,        1, ST_REARRANGED, 22'd0,  7'd0},
      '{ACT_FREE,    24'd32,       24'd0,        1, ST_NEW_SLOT,   22'd0,  7'd1},
      '{ACT_FREE,    24'd64,       24'd1024,     0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_FREE,    24'd1,        24'd992,      0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_FREE,    24'd100,      24'd1500,     0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_ALLOC,   24'd96,       24'd0,        0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_SORT,    24'd0,        24'd0,        0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_FREE,    24'd32,       24'd2047,     0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_ALLOC,   24'd32,       24'd0,        0, ST_ALLOCATED,  22'd0,  7'd0},
      '{ACT_SORT,    24'd0,        24'd0,        0, ST_ALLOCATED,  22'd0,  7'd0}
   };

   initial begin
      blk_log2 = 5;
      ring_init();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (directed_rows[i])
         send(directed_rows[i].act, directed_rows[i].size, directed_rows[i].off,
              directed_rows[i].typed, directed_rows[i].st, directed_rows[i].roff,
              directed_rows[i].slots);

      // fill the ring to capacity, overflow it, then sort and merge
      write_block_log2(5'd5);
      send(ACT_ALLOC, 24'd2048, '0);
      for (int k = 0; k < RING; k++) send(ACT_FREE, 24'd32, 24'(32 * k));
      send(ACT_FREE, 24'd32, 24'd2016);
      send(ACT_SORT, '0, '0);
      send(ACT_FREE, 24'd32, 24'd32);
      send(ACT_ALLOC, 24'd64, '0);

      write_block_log2(5'd0);
      random_phase(150);
      write_block_log2(5'd5);
      random_phase(150);
      write_block_log2(5'd16);
      random_phase(150);
      write_block_log2(5'd31);
      random_phase(150);
      write_block_log2(5'($urandom_range(1, 15)));
      random_phase(150);
      write_block_log2(5'd3);
      random_phase(150);

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d request transfers and %0d response transfers over six block sizes",
               transfers, results_seen);
      $display("ring overflows seen: %0d, merged frees: %0d", full_hits, merges);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("ring_free_list_allocator_top_test: clean");
      end else begin
         $display("ring_free_list_allocator_top_test: errors");
      end
      $finish;
   end

   initial begin
      #1000000000;
      $display("timeout with %0d responses outstanding", awaited_results.size());
      $display("ring_free_list_allocator_top_test: errors");
      $finish;
   end

endmodule
